// ----- rtl/swm_pkg.sv -----
// Shared constants and controller/datapath handshake structs for the
// sliding-window median unit. No dependencies.

package swm_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_BITS        = 7;
	localparam int WINDOW_RESET    = 3;

	// controller -> datapath
	typedef struct packed {
		logic load_in;   // capture item, read oldest ring slot, write new one
		logic drop;      // remove oldest value from sorted row
		logic insert;    // insert new value into sorted row
		logic load_out;  // register median into output stage
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;       // fill count equals window size
		logic last_free;  // one slot left before the window is full
	} sts_t;

endpackage

// ----- rtl/swm_if.sv -----
// Item channels of the sliding-window median unit: sample in, median out,
// window size configuration. Depends on swm_pkg.

interface swm_sample_if #(
	parameter int W = swm_pkg::SAMPLE_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
	parameter int W = swm_pkg::SAMPLE_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface

interface swm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [swm_pkg::CFG_BITS-1:0]  window_size;

	modport source (output valid, output window_size, input ready);
	modport sink   (input valid, input window_size, output ready);
endinterface

// ----- rtl/swm_ctrl.sv -----
// Sequencer for the sliding-window median unit: ring read, remove pass,
// insert pass, output load. Depends on swm_pkg.

module swm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output swm_pkg::cmd_t  cmd,
	input  swm_pkg::sts_t  sts
);
	import swm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DROP = 4'b0010,
		ST_INS  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = accept;
		cmd.drop     = (state_q == ST_DROP) && sts.full;
		cmd.insert   = (state_q == ST_INS);
		cmd.load_out = (state_q == ST_OUT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DROP;
			end
			ST_DROP: begin
				state_d = ST_INS;
			end
			ST_INS: begin
				state_d = sts.last_free ? ST_OUT : ST_IDLE;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DROP) && !in_ready)
		else $error("accepted item did not start remove pass");

	a_drop_ins: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DROP) |=> (state_q == ST_INS))
		else $error("remove pass not followed by insert pass");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && !sts.last_free) |=> (state_q == ST_IDLE))
		else $error("partial window went on to output");

endmodule

// ----- rtl/swm_dp.sv -----
// Datapath of the sliding-window median unit: sample ring memory, sorted
// cell row with parallel remove/insert, counters, output register.
// Depends on swm_pkg.

module swm_dp #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swm_pkg::cmd_t                  cmd,
	output swm_pkg::sts_t                  sts,
	input  logic                           cfg_we,
	input  logic [swm_pkg::CFG_BITS-1:0]   cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	output logic signed [SAMPLE_BITS-1:0]  median
);
	import swm_pkg::*;

	localparam int KW    = $clog2(WINDOW_MAX + 1);
	localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW    = (KW > CFG_BITS) ? KW : CFG_BITS;
	localparam int K_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;
	localparam int M_RST = (K_RST - 1) / 2;

	logic signed [SAMPLE_BITS-1:0] ring_q   [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] sorted_q [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] new_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic signed [SAMPLE_BITS-1:0] median_q;

	logic [KW-1:0] k_q;
	logic [KW-1:0] fill_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] med_idx_q;

	logic [CW-1:0] cfg_ext;
	logic [CW-1:0] cfg_clamp;
	logic [KW-1:0] k_d;
	logic [KW-1:0] k_dec;

	logic [WINDOW_MAX-1:0] ge;
	logic [WINDOW_MAX-1:0] gt;

	// window size clamp: zero reads as one, above maximum saturates
	always_comb begin
		cfg_ext = CW'(cfg_data);
		if (cfg_ext == '0) cfg_clamp = CW'(1);
		else if (cfg_ext > CW'(WINDOW_MAX)) cfg_clamp = CW'(WINDOW_MAX);
		else cfg_clamp = cfg_ext;
		k_d   = KW'(cfg_clamp);
		k_dec = k_d - KW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= KW'(K_RST);
			med_idx_q <= PW'(M_RST);
			fill_q    <= '0;
			ptr_q     <= '0;
		end else if (cfg_we) begin
			k_q       <= k_d;
			med_idx_q <= PW'(k_dec >> 1);
			fill_q    <= '0;
			ptr_q     <= '0;
		end else begin
			if (cmd.drop) fill_q <= fill_q - KW'(1);
			else if (cmd.insert) fill_q <= fill_q + KW'(1);
			if (cmd.load_in) begin
				if ({{(KW - PW + 1){1'b0}}, ptr_q} + (KW + 1)'(1) == {1'b0, k_q})
					ptr_q <= '0;
				else
					ptr_q <= ptr_q + PW'(1);
			end
		end
	end

	// ring memory, read-before-write at the oldest slot
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ring_q[ptr_q] <= sample;
			old_q         <= ring_q[ptr_q];
			new_q         <= sample;
		end
	end

	// per-cell compares; the row is sorted so both masks are monotonic
	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			ge[i] = (KW'(i) < fill_q) && (sorted_q[i] >= old_q);
			gt[i] = (KW'(i) < fill_q) && (sorted_q[i] > new_q);
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic shift_in;
		logic take_new;

		if (i == 0) begin : g_first
			assign shift_in = 1'b0;
		end else begin : g_rest
			assign shift_in = gt[i-1];
		end
		assign take_new = gt[i] || (KW'(i) == fill_q);

		always_ff @(posedge clk) begin
			if (cmd.drop) begin
				if (i < WINDOW_MAX - 1 && ge[i])
					sorted_q[i] <= sorted_q[(i < WINDOW_MAX - 1) ? i + 1 : i];
			end else if (cmd.insert) begin
				if (shift_in)
					sorted_q[i] <= sorted_q[(i > 0) ? i - 1 : i];
				else if (take_new)
					sorted_q[i] <= new_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) median_q <= sorted_q[med_idx_q];
	end

	always_comb begin
		sts           = '0;
		sts.full      = (fill_q == k_q);
		sts.last_free = ({1'b0, fill_q} + (KW + 1)'(1) == {1'b0, k_q});
	end

	assign median = median_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_q)
		else $error("fill count beyond window size");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		KW'(ptr_q) < k_q)
		else $error("ring pointer beyond window size");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> (fill_q == k_q) && !cmd.insert)
		else $error("remove pass on a partial window");

endmodule

// ----- rtl/sliding_window_median_unit.sv -----
// Sliding-window median unit: lower median of the last k samples.
// Median valid follows remove pass, insert pass and an output load that waits on
// back-pressure; no result while filling. A new item is taken only in idle, once
// ring read, remove pass, insert pass over the cell row and any output load end.
// Reset: window empty, window size 3; store contents undefined, no clearing pass.
// Depends on swm_pkg, swm_if, swm_ctrl, swm_dp.

module sliding_window_median_unit #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	swm_sample_if.sink   samples,
	swm_median_if.source medians,
	swm_cfg_if.sink      cfg
);
	import swm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (medians.valid),
		.out_ready (medians.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	swm_dp #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.window_size),
		.sample   (samples.sample),
		.median   (medians.median)
	);

endmodule

// ----- test/swm_median_checker.sv -----
// Checker for the sliding-window median unit: watches the sample, median and
// window-size channels, keeps its own window, and compares every median item.
// Depends on swm_pkg.

module swm_median_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_ready,
	input  logic [31:0] sample,
	input  logic        median_valid,
	input  logic        median_ready,
	input  logic [31:0] median,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_size,
	output int          errors,
	output int          pending
);

	import swm_pkg::*;

	logic signed [31:0] ring_store [WINDOW_MAX_DEF];
	logic signed [31:0] sorted_row [WINDOW_MAX_DEF];
	int                 win_len;
	int                 fill;
	int                 slot;
	logic signed [31:0] medians_due [$];

	// Advance the window by one sample; returns 1 when the window is full.
	function automatic bit slide_window(input logic signed [31:0] v,
			output logic signed [31:0] med);
		int pos;
		logic signed [31:0] oldest;
		med = '0;
		if (slot >= win_len)
			slot = 0;
		if (fill > win_len)
			fill = win_len;
		if (fill == win_len) begin
			oldest = ring_store[slot];
			pos = 0;
			while (pos < fill - 1 && sorted_row[pos] != oldest)
				pos++;
			for (int j = pos; j < fill - 1; j++)
				sorted_row[j] = sorted_row[j + 1];
			fill--;
		end
		pos = 0;
		while (pos < fill && !(v < sorted_row[pos]))
			pos++;
		for (int j = fill; j > pos; j--)
			sorted_row[j] = sorted_row[j - 1];
		sorted_row[pos] = v;
		fill++;
		ring_store[slot] = v;
		slot++;
		if (slot >= win_len)
			slot = 0;
		if (fill < win_len)
			return 1'b0;
		med = sorted_row[(win_len + 1) / 2 - 1];
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] med_exp;
		if (!arst_n) begin
			win_len = WINDOW_RESET;
			fill    = 0;
			slot    = 0;
			errors  = 0;
			medians_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_len = (cfg_size == 0) ? 1 :
					(cfg_size > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(cfg_size);
				fill = 0;
				slot = 0;
			end
			if (sample_valid && sample_ready) begin
				if (slide_window($signed(sample), med_exp))
					medians_due.push_back(med_exp);
			end
			if (median_valid && median_ready) begin
				if (medians_due.size() == 0) begin
					$display("%0t unexpected median item: expected none, got %0d",
						$time, $signed(median));
					errors++;
				end else begin
					med_exp = medians_due.pop_front();
					if (median !== med_exp) begin
						$display("%0t median mismatch: expected %0d, got %0d",
							$time, med_exp, $signed(median));
						errors++;
					end
				end
			end
			pending = medians_due.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
// Top of the sliding-window median unit test: clock, reset, sample stimulus,
// window-size writes, output back-pressure and the verdict.
// Depends on swm_pkg, swm_if, sliding_window_median_unit, swm_median_checker.

module testbench;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   errors;
	int   pending;
	bit   calm = 1'b0;
	logic signed [31:0] last_sample = '0;

	swm_sample_if #(.W(32)) sample_ch ();
	swm_median_if #(.W(32)) median_ch ();
	swm_cfg_if              cfg_ch ();

	sliding_window_median_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.medians (median_ch),
		.cfg     (cfg_ch)
	);

	swm_median_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_ch.valid),
		.sample_ready (sample_ch.ready),
		.sample       (sample_ch.sample),
		.median_valid (median_ch.valid),
		.median_ready (median_ch.ready),
		.median       (median_ch.median),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_size     (cfg_ch.window_size),
		.errors       (errors),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// output back-pressure in bursts
	initial begin
		median_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				median_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			median_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	task automatic send_sample(input logic signed [31:0] v, input bit gaps);
		if (gaps && !calm && $urandom_range(0, 5) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= v;
		last_sample = v;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// drain, let item-less work settle, then write the window size
	task automatic write_window(input logic [6:0] sz);
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.window_size <= sz;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 9))
			4, 5:    return $urandom_range(0, 8) - 4;
			6: begin
				case ($urandom_range(0, 3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return '0;
					default: return '1;
				endcase
			end
			7:       return last_sample;
			8, 9:    return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int   sent;
		int   keff;
		int   count;
		bit   gaps;
		logic [6:0] sz;
		logic [6:0] first_sizes [5];

		first_sizes        = '{7'd64, 7'd1, 7'd127, 7'd65, 7'd2};
		arst_n             <= 1'b0;
		sample_ch.valid    <= 1'b0;
		sample_ch.sample   <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.window_size <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window of three after reset: extremes and duplicates
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(32'sh7fff_ffff, 1'b1);
		send_sample(32'sh0000_0000, 1'b1);
		send_sample(-32'sd1, 1'b1);
		send_sample(32'sd1, 1'b1);
		send_sample(32'sd5, 1'b1);
		send_sample(32'sd5, 1'b1);
		send_sample(32'sd5, 1'b1);
		send_sample(32'sh7fff_ffff, 1'b1);
		send_sample(32'sh8000_0000, 1'b1);

		// size zero behaves as one
		write_window(7'd0);
		send_sample(32'sd7, 1'b1);
		send_sample(-32'sd7, 1'b1);
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(32'sh7fff_ffff, 1'b1);

		// even window: lower median
		write_window(7'd2);
		send_sample(32'sd3, 1'b1);
		send_sample(32'sd1, 1'b1);
		send_sample(32'sd1, 1'b1);
		send_sample(32'sd4, 1'b1);
		send_sample(-32'sd1, 1'b1);
		send_sample(-32'sd1, 1'b1);

		sent = 0;
		for (int ph = 0; sent < 1000; ph++) begin
			if (ph < 5)
				sz = first_sizes[ph];
			else if ($urandom_range(0, 3) != 0)
				sz = 7'($urandom_range(1, 12));
			else
				sz = 7'($urandom_range(0, 127));
			keff = (sz == 0) ? 1 : (sz > 64) ? 64 : int'(sz);
			write_window(sz);
			gaps  = ($urandom_range(0, 3) != 0);
			count = keff + int'($urandom_range(4, 40));
			for (int i = 0; i < count; i++) begin
				send_sample(pick_sample(), gaps);
				sent++;
				if (sent >= 880)
					calm = 1'b1;
			end
		end

		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
